// File: hdl/ddpi_pkg.sv
// ============================================================================
// ddpi_pkg - shared types and constants for the pose integrator
// Item structs, fixed-point constants, arctangent table and helpers.
// ============================================================================
package ddpi_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int MUL_AW = 40;
    localparam int MUL_BW = 34;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int DIV_NW = 40;
    localparam int DIV_DW = 24;

    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] RAD_TO_BA = 34'sd683565276;

    typedef struct packed {
        logic              cmd;
        logic signed [23:0] linear_speed;
        logic signed [23:0] angular_rate;
        logic [23:0]        elapsed_time;
    } ddpi_in_t;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic [31:0]        heading;
        logic signed [31:0] orient_z;
        logic signed [31:0] orient_w;
    } ddpi_out_t;

    function automatic logic [31:0] atan_ba(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000000;
            5'd31: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
        logic signed [39:0] r;
        if (v > 44'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 44'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/diff_drive_pose_integrator_top.sv
// ============================================================================
// diff_drive_pose_integrator_top - planar arc odometry integrator
// Sequencer around a bit-serial multiplier, divider and CORDIC.
// ============================================================================
// A command item (cmd=0) only stores speed and turn rate; it also starts the
// radius divider, whose result is latched when it finishes, well before a
// following tick reads it.
// A tick item (cmd=1) runs a sequence on shared serial units: two products
// for the heading step, a CORDIC of the old heading, then either four
// products (straight) or a CORDIC and two products (arc), and a final CORDIC
// for the quaternion. Each product consumes one bit of the 34-bit second
// operand per cycle, and a tick holds the input off for its whole sequence.
// A new item is accepted once the sequencer is idle, while a finished pose
// may still wait in the output register.
module diff_drive_pose_integrator_top import ddpi_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ddpi_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ddpi_out_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [22:0] cfg_wr_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DTH1, ST_DTH2, ST_COS0, ST_SX1, ST_SX2, ST_SY1, ST_SY2,
        ST_COS1, ST_AX, ST_AY, ST_UPDATE, ST_QUAT, ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [22:0]        thr_reg;
    logic signed [23:0] v_reg, w_reg;
    logic [23:0]        dt_reg;
    logic signed [39:0] px_reg, py_reg;
    logic [31:0]        hd_reg, h1_reg;
    logic signed [31:0] s0_reg, c0_reg, c1_reg;
    logic signed [42:0] dx_reg, dy_reg;
    logic signed [39:0] r_reg;
    logic               m_valid_reg;
    ddpi_out_t          m_data_reg;

    logic                     mul_start_reg;
    logic signed [MUL_AW-1:0] mul_a_reg;
    logic signed [MUL_BW-1:0] mul_b_reg;
    logic                     mul_done;
    logic signed [MUL_PW-1:0] prod;

    logic              div_start_reg;
    logic [DIV_NW-1:0] div_num_reg;
    logic [DIV_DW-1:0] div_den_reg;
    logic              div_neg_reg;
    logic              div_done;
    logic [DIV_NW-1:0] quo;

    logic               cor_start_reg;
    logic [31:0]        cor_angle_reg;
    logic               cor_done;
    logic signed [31:0] cor_sin, cor_cos;

    logic signed [MUL_PW-1:0] p15, p23, p29;
    logic signed [40:0]       r_full;
    logic signed [39:0]       r_sat;
    logic [23:0]              mag_w, v_abs;
    logic                     straight;
    logic signed [43:0]       nx_sum, ny_sum;

    ddpi_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a(mul_a_reg), .b(mul_b_reg), .done(mul_done), .prod(prod)
    );

    ddpi_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(div_num_reg), .den(div_den_reg), .done(div_done), .quo(quo)
    );

    ddpi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start_reg),
        .angle(cor_angle_reg), .done(cor_done), .sin_out(cor_sin), .cos_out(cor_cos)
    );

    // rounding offsets ahead of the floor shifts
    assign p15 = prod + MUL_PW'(32768);
    assign p23 = prod + MUL_PW'(8388608);
    assign p29 = prod + MUL_PW'(536870912);

    assign r_full = div_neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign r_sat  = (!div_neg_reg && quo[DIV_NW-1]) ? POS_MAX : r_full[39:0];

    assign mag_w    = w_reg[23] ? 24'(-w_reg) : 24'(w_reg);
    assign v_abs    = s_data.linear_speed[23] ? 24'(-s_data.linear_speed)
                                              : 24'(s_data.linear_speed);
    assign straight = (mag_w < {1'b0, thr_reg}) || (w_reg == '0);

    assign nx_sum = {{4{px_reg[39]}}, px_reg} + {dx_reg[42], dx_reg};
    assign ny_sum = {{4{py_reg[39]}}, py_reg} + {dy_reg[42], dy_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= 23'd1;
            v_reg         <= '0;
            w_reg         <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (div_done) begin
                r_reg <= r_sat;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!s_data.cmd) begin
                            v_reg <= s_data.linear_speed;
                            w_reg <= s_data.angular_rate;
                            div_num_reg <= {v_abs, 16'd0};
                            div_den_reg <= s_data.angular_rate[23]
                                ? 24'(-s_data.angular_rate) : 24'(s_data.angular_rate);
                            div_neg_reg <= s_data.linear_speed[23] ^ s_data.angular_rate[23];
                            div_start_reg <= 1'b1;
                        end else begin
                            dt_reg        <= s_data.elapsed_time;
                            mul_a_reg     <= {{16{w_reg[23]}}, w_reg};
                            mul_b_reg     <= {10'd0, s_data.elapsed_time};
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_DTH1;
                        end
                    end
                end
                ST_DTH1: begin
                    if (mul_done) begin
                        mul_a_reg     <= {{7{p15[48]}}, p15[48:16]};
                        mul_b_reg     <= RAD_TO_BA;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_DTH2;
                    end
                end
                ST_DTH2: begin
                    if (mul_done) begin
                        h1_reg        <= hd_reg + p23[55:24];
                        cor_angle_reg <= hd_reg;
                        cor_start_reg <= 1'b1;
                        state_reg     <= ST_COS0;
                    end
                end
                ST_COS0: begin
                    if (cor_done) begin
                        s0_reg <= cor_sin;
                        c0_reg <= cor_cos;
                        if (straight) begin
                            mul_a_reg     <= {{16{v_reg[23]}}, v_reg};
                            mul_b_reg     <= {{2{cor_cos[31]}}, cor_cos};
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_SX1;
                        end else begin
                            cor_angle_reg <= h1_reg;
                            cor_start_reg <= 1'b1;
                            state_reg     <= ST_COS1;
                        end
                    end
                end
                ST_SX1, ST_SY1: begin
                    if (mul_done) begin
                        mul_a_reg     <= {{15{p29[54]}}, p29[54:30]};
                        mul_b_reg     <= {10'd0, dt_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= (state_reg == ST_SX1) ? ST_SX2 : ST_SY2;
                    end
                end
                ST_SX2: begin
                    if (mul_done) begin
                        dx_reg        <= p23[66:24];
                        mul_a_reg     <= {{16{v_reg[23]}}, v_reg};
                        mul_b_reg     <= {{2{s0_reg[31]}}, s0_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SY1;
                    end
                end
                ST_SY2: begin
                    if (mul_done) begin
                        dy_reg    <= p23[66:24];
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_COS1: begin
                    if (cor_done) begin
                        c1_reg        <= cor_cos;
                        mul_a_reg     <= r_reg;
                        mul_b_reg     <= {{2{cor_sin[31]}}, cor_sin}
                                         - {{2{s0_reg[31]}}, s0_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AX;
                    end
                end
                ST_AX: begin
                    if (mul_done) begin
                        dx_reg        <= p29[72:30];
                        mul_a_reg     <= r_reg;
                        mul_b_reg     <= {{2{c0_reg[31]}}, c0_reg}
                                         - {{2{c1_reg[31]}}, c1_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AY;
                    end
                end
                ST_AY: begin
                    if (mul_done) begin
                        dy_reg    <= p29[72:30];
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    px_reg        <= sat40(nx_sum);
                    py_reg        <= sat40(ny_sum);
                    hd_reg        <= h1_reg;
                    cor_angle_reg <= {h1_reg[31], h1_reg[31:1]};
                    cor_start_reg <= 1'b1;
                    state_reg     <= ST_QUAT;
                end
                ST_QUAT: begin
                    if (cor_done) begin
                        s0_reg    <= cor_sin;
                        c0_reg    <= cor_cos;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.pos_x    <= px_reg;
                        m_data_reg.pos_y    <= py_reg;
                        m_data_reg.heading  <= hd_reg;
                        m_data_reg.orient_z <= s0_reg;
                        m_data_reg.orient_w <= c0_reg;
                        m_valid_reg         <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_DTH1 || state_reg == ST_DTH2 ||
                      state_reg == ST_SX1 || state_reg == ST_SX2 ||
                      state_reg == ST_SY1 || state_reg == ST_SY2 ||
                      state_reg == ST_AX || state_reg == ST_AY))
        else $error("multiplier finished outside a product state");

    a_cor_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_done |-> (state_reg == ST_COS0 || state_reg == ST_COS1 ||
                      state_reg == ST_QUAT))
        else $error("CORDIC finished outside a rotation state");

    a_cmd_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.cmd) |=> (state_reg == ST_IDLE))
        else $error("command item started a sequence");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit");
`endif

endmodule

// File: hdl/ddpi_mul.sv
// ============================================================================
// ddpi_mul - bit-serial signed multiplier
// Consumes one bit of operand b per cycle, MSB first, shift-and-add.
// ============================================================================
module ddpi_mul import ddpi_pkg::*; #(
    parameter int AW = MUL_AW,
    parameter int BW = MUL_BW
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic                     done,
    output logic signed [AW+BW-1:0]  prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW);

    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] a_ext_reg;
    logic [BW-1:0]        b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [PW-1:0] a_ext;

    assign a_ext = {{BW{a[AW-1]}}, a};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_ext_reg <= a_ext;
                acc_reg   <= b[BW-1] ? -a_ext : '0;
                b_reg     <= {b[BW-2:0], 1'b0};
                cnt_reg   <= CW'(BW - 1);
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= (acc_reg <<< 1) + (b_reg[BW-1] ? a_ext_reg : '0);
                b_reg   <= {b_reg[BW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hdl/ddpi_div.sv
// ============================================================================
// ddpi_div - bit-serial restoring divider
// Unsigned quotient, one quotient bit per cycle.
// ============================================================================
module ddpi_div import ddpi_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                num_reg <= {num_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// File: hdl/ddpi_cordic.sv
// ============================================================================
// ddpi_cordic - iterative rotation-mode CORDIC
// One micro-rotation per cycle; sine and cosine of a binary angle in Q2.30.
// ============================================================================
module ddpi_cordic import ddpi_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] sin_out,
    output logic signed [31:0] cos_out
);
    localparam int IW = $clog2(STEPS);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               neg_reg;
    logic [IW-1:0]      i_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [31:0] sin_reg, cos_reg;

    logic signed [33:0] za, xs, ys, at, xn, yn;

    assign za = {{2{angle[31]}}, angle};
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = {2'b00, atan_ba(5'(i_reg))};
    assign xn = neg_reg ? -x_reg : x_reg;
    assign yn = neg_reg ? -y_reg : y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                x_reg    <= CORDIC_START;
                y_reg    <= '0;
                i_reg    <= '0;
                busy_reg <= 1'b1;
                if (za > ONE_Q30) begin
                    z_reg   <= za - HALF_TURN;
                    neg_reg <= 1'b1;
                end else if (za < -ONE_Q30) begin
                    z_reg   <= za + HALF_TURN;
                    neg_reg <= 1'b1;
                end else begin
                    z_reg   <= za;
                    neg_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                cos_reg  <= clamp_q30(xn);
                sin_reg  <= clamp_q30(yn);
                done_reg <= 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// File: tb/sv/tb_diff_drive_pose_integrator_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_diff_drive_pose_integrator_top - pose integrator testbench
// Drives command and tick items with random idling on both channels. A
// fixed-point predictor of the odometry update forms the expected pose for
// every tick, and the monitor compares each pose field by field.
// ============================================================================
module tb_diff_drive_pose_integrator_top;
    import ddpi_pkg::*;

    localparam int  STEPS       = 24;
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam int  IDLE_CYCLES = 400;
    localparam longint LIMIT    = 4000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ddpi_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ddpi_out_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [22:0] cfg_wr_data = '0;

    diff_drive_pose_integrator_top #(.CORDIC_STEPS(STEPS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    ddpi_in_t  pending_items[$];
    ddpi_out_t expected_poses[$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        calm = 0;
    bit        hold_sink = 0;
    bit        hold_src = 0;
    bit        in_taken = 0;
    int        sink_hold_left = 0;

    // predictor state
    longint    thr_q;
    longint    spd_q, rate_q, px_q, py_q;
    bit [31:0] hdg_q;

    localparam longint ATAN_TAB[32] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
        'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001,
        0, 0};

    function automatic longint rnd_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic rotate(input bit [31:0] a, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit neg;
        z = a;
        x = 652032874;
        y = 0;
        neg = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; neg = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; neg = 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = clip(x, -64'sd1073741824, 64'sd1073741824);
        s = clip(y, -64'sd1073741824, 64'sd1073741824);
    endtask

    function automatic longint scale_q30(longint r, longint d);
        longint rh, rl, q, qh, ql, p;
        rh = r >>> 16;
        rl = r - rh * 65536;
        q  = rh * d;
        qh = q >>> 14;
        ql = q - qh * 16384;
        p  = rl * d + (64'sd1 <<< 29);
        return qh + ((ql * 65536 + p) >>> 30);
    endfunction

    task automatic integrate_pose(input ddpi_in_t it);
        longint dt, dth, dx, dy, s0, c0, s1, c1, r, mag;
        longint pmax, pmin;
        bit [31:0] h1, half;
        ddpi_out_t o;
        pmax = 64'sd549755813887;
        pmin = -64'sd549755813888;
        if (it.cmd == CMD_STORE) begin
            spd_q  = longint'(it.linear_speed);
            rate_q = longint'(it.angular_rate);
            return;
        end
        dt  = longint'({1'b0, it.elapsed_time});
        dth = rnd_sh(rnd_sh(rate_q * dt, 16) * 683565276, 24);
        h1  = hdg_q + dth[31:0];
        rotate(hdg_q, s0, c0);
        mag = rate_q < 0 ? -rate_q : rate_q;
        if (mag < thr_q || rate_q == 0) begin
            dx = rnd_sh(rnd_sh(spd_q * c0, 30) * dt, 24);
            dy = rnd_sh(rnd_sh(spd_q * s0, 30) * dt, 24);
        end else begin
            r = clip((spd_q * 65536) / rate_q, pmin, pmax);
            rotate(h1, s1, c1);
            dx = scale_q30(r, s1 - s0);
            dy = scale_q30(r, c0 - c1);
        end
        px_q  = clip(px_q + dx, pmin, pmax);
        py_q  = clip(py_q + dy, pmin, pmax);
        hdg_q = h1;
        half  = (hdg_q >> 1) | (hdg_q & 32'h8000_0000);
        rotate(half, s1, c1);
        o.pos_x    = px_q[39:0];
        o.pos_y    = py_q[39:0];
        o.heading  = hdg_q;
        o.orient_z = s1[31:0];
        o.orient_w = c1[31:0];
        expected_poses.push_back(o);
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic ddpi_in_t mk_cmd(logic [23:0] v, logic [23:0] w);
        ddpi_in_t it;
        it = '0;
        it.cmd = CMD_STORE;
        it.linear_speed = v;
        it.angular_rate = w;
        it.elapsed_time = 24'($urandom);
        return it;
    endfunction

    function automatic ddpi_in_t mk_tick(logic [23:0] dt);
        ddpi_in_t it;
        it = '0;
        it.cmd = CMD_TICK;
        it.elapsed_time = dt;
        it.linear_speed = 24'($urandom);
        it.angular_rate = 24'($urandom);
        return it;
    endfunction

    function automatic logic [23:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 131072)) - 65536);
            2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // input acceptance, sampled at the rising edge; predictor runs here
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            integrate_pose(s_data);
            void'(pending_items.pop_front());
        end
        in_taken <= aresetn && s_valid && s_ready;
    end

    // driver: feeds queued items
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_items.size() > 0 && !hold_src
                    && (calm || $urandom_range(0, 99) >= 24)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_poses.size() == 0) begin
                $display("unexpected pose at cycle %0d", cycles);
                mismatches++;
            end else begin
                ddpi_out_t e;
                e = expected_poses.pop_front();
                if (m_data.pos_x !== e.pos_x) report_mismatch("pos_x", m_data.pos_x, e.pos_x);
                if (m_data.pos_y !== e.pos_y) report_mismatch("pos_y", m_data.pos_y, e.pos_y);
                if (m_data.heading !== e.heading)
                    report_mismatch("heading", 40'(m_data.heading), 40'(e.heading));
                if (m_data.orient_z !== e.orient_z)
                    report_mismatch("orient_z", 40'(m_data.orient_z), 40'(e.orient_z));
                if (m_data.orient_w !== e.orient_w)
                    report_mismatch("orient_w", 40'(m_data.orient_w), 40'(e.orient_w));
            end
        end
        if (cycles >= LIMIT) begin
            $display("diff_drive_pose_integrator_top test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_sink) begin
            sink_hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || $urandom_range(0, 99) >= 24;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_poses.size() > 0)
            @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [22:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        thr_q = longint'({1'b0, v});
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                logic [23:0] w;
                case ($urandom_range(0, 4))
                    0: w = 24'($urandom);
                    1: w = 24'($signed($urandom_range(0, 64)) - 32);
                    2: w = 24'($signed($urandom_range(0, 400000)) - 200000);
                    3: w = '0;
                    default: w = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                endcase
                pending_items.push_back(mk_cmd(rand_speed(), w));
            end else begin
                logic [23:0] dt;
                case ($urandom_range(0, 3))
                    0: dt = 24'($urandom);
                    1: dt = 24'($urandom_range(0, 70000));
                    2: dt = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
                    default: dt = 24'($urandom_range(0, 2000000));
                endcase
                pending_items.push_back(mk_tick(dt));
            end
        end
    endtask

    initial begin
        thr_q = 1;
        spd_q = 0; rate_q = 0; px_q = 0; py_q = 0; hdg_q = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        pending_items.push_back(mk_tick(24'hFFFFFF));
        pending_items.push_back(mk_cmd(24'h7FFFFF, 24'h000000));
        pending_items.push_back(mk_tick(24'hFFFFFF));
        pending_items.push_back(mk_tick(24'h000000));
        pending_items.push_back(mk_cmd(24'h800000, 24'h7FFFFF));
        pending_items.push_back(mk_tick(24'hFFFFFF));
        pending_items.push_back(mk_cmd(24'h010000, 24'h800000));
        pending_items.push_back(mk_tick(24'hFFFFFF));
        pending_items.push_back(mk_cmd(24'h7FFFFF, 24'h000001));
        pending_items.push_back(mk_tick(24'h800000));
        pending_items.push_back(mk_cmd(24'h800000, 24'hFFFFFF));
        pending_items.push_back(mk_tick(24'h123456));
        pending_items.push_back(mk_cmd(24'h032000, 24'h030000));
        pending_items.push_back(mk_tick(24'h400000));
        pending_items.push_back(mk_tick(24'h000000));
        wait_drained();

        write_threshold(23'd0);
        pending_items.push_back(mk_cmd(24'h020000, 24'h000000));
        pending_items.push_back(mk_tick(24'hFFFFFF));
        pending_items.push_back(mk_cmd(24'h020000, 24'h000001));
        pending_items.push_back(mk_tick(24'h100000));
        random_phase(400);
        wait_drained();

        write_threshold(23'h7FFFFF);
        random_phase(400);
        wait_drained();

        write_threshold(23'd64);
        calm = 1;
        random_phase(300);
        wait_drained();
        calm = 0;

        write_threshold(23'($urandom_range(0, 300000)));
        random_phase(400);
        @(negedge aclk);
        hold_sink = 1;
        wait (sink_hold_left > 0);
        hold_sink = 0;
        wait_drained();

        write_threshold(23'd1);
        random_phase(250);
        hold_src = 1;
        while (expected_poses.size() > 0 || (s_valid && pending_items.size() > 0
               && expected_poses.size() > 0)) @(posedge aclk);
        hold_src = 0;
        random_phase(250);
        wait_drained();

        if (mismatches == 0) begin
            $display("diff_drive_pose_integrator_top test passed");
        end else begin
            $display("diff_drive_pose_integrator_top test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ddpi_pkg.sv
hdl/ddpi_mul.sv
hdl/ddpi_div.sv
hdl/ddpi_cordic.sv
hdl/diff_drive_pose_integrator_top.sv
tb/sv/tb_diff_drive_pose_integrator_top.sv
